// ===== hw/rtl/first_free_slot_allocator_defines.svh =====
// Assertion macros used by the slot allocator datapath.
`ifndef FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH
`define FIRST_FREE_SLOT_ALLOCATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FFSA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FFSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ffsa_pkg.sv =====
package ffsa_pkg;

  // Field widths.
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned OWNER_W   = 31;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned SLOT_W    = 6;
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned SIU_W     = 7;

  // Default slot count and reset value of the active slot limit.
  localparam int unsigned MAX_SLOTS_DEF = 64;
  localparam logic [SIU_W-1:0] SIU_RESET = 7'd64;

  // Request actions; the unused code acts as a map read.
  localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_MAP     = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STS_ALLOCATED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_RELEASED  = 3'd1;
  localparam logic [STATUS_W-1:0] STS_HOLDS     = 3'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] STS_MAP       = 3'd5;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OWNER_W-1:0]  owner_id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_number;
    logic [MAP_W-1:0]    occupancy_bits;
  } rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic map_rd;
    logic issue;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/ffsa_datapath.sv =====
`include "first_free_slot_allocator_defines.svh"

module ffsa_datapath import ffsa_pkg::*; #(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SIU_W-1:0] cfg_wdata_i,
  input  req_t             req_i,
  input  dp_cmd_t          cmd_i,
  output dp_sts_t          sts_o,
  output logic             rsp_vld_o,
  output rsp_t             rsp_o
);

  localparam int unsigned IdxW = $clog2(MaxSlots);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MaxSlots - 1);

  logic [SIU_W-1:0]   slots_in_use_q;
  logic [MaxSlots-1:0] taken_q, taken_d;
  logic [OWNER_W-1:0] owner_mem [MaxSlots];
  logic [OWNER_W-1:0] rd_data_q;
  logic [OWNER_W-1:0] owner_q;
  logic               alloc_q;
  logic [IdxW-1:0]    idx_q;
  logic [IdxW-1:0]    cmp_idx_q;
  logic               cmp_vld_q;
  logic               hit_q;
  logic [IdxW-1:0]    hit_idx_q;
  logic               free_q;
  logic [IdxW-1:0]    free_idx_q;
  logic               rsp_vld_q, rsp_vld_d;
  rsp_t               rsp_q, rsp_d;
  logic               mem_we;
  logic               cmp_hit;
  logic               cmp_free;
  logic [MAP_W-1:0]   map_bits;

  // Active slot limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_in_use_q <= SIU_RESET;
    end else if (cfg_we_i) begin
      slots_in_use_q <= cfg_wdata_i;
    end
  end

  // Owner tag memory: one read port for the scan, one write at finish.
  assign mem_we = cmd_i.finish && alloc_q && !hit_q && free_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      owner_mem[free_idx_q] <= owner_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_data_q <= owner_mem[idx_q];
      cmp_idx_q <= idx_q;
    end
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      owner_q <= req_i.owner_id;
      alloc_q <= (req_i.action == ACT_ALLOC);
    end
  end

  // Scan counter and compare pipeline valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.issue;
      if (cmd_i.load) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  assign sts_o.scan_last = (idx_q == LastIdx);

  // Compare one tag per cycle; remember the owner's slot and the first free slot.
  assign cmp_hit  = taken_q[cmp_idx_q] && (rd_data_q == owner_q);
  assign cmp_free = !taken_q[cmp_idx_q] && (SIU_W'(cmp_idx_q) < slots_in_use_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmd_i.load) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
    end else if (cmp_vld_q) begin
      if (cmp_hit && !hit_q) begin
        hit_q <= 1'b1;
      end
      if (cmp_free && !free_q) begin
        free_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmp_vld_q && cmp_hit && !hit_q) begin
      hit_idx_q <= cmp_idx_q;
    end
    if (cmp_vld_q && cmp_free && !free_q) begin
      free_idx_q <= cmp_idx_q;
    end
  end

  // Occupancy map, zero above the implemented slots.
  always_comb begin
    map_bits = '0;
    map_bits[MaxSlots-1:0] = taken_q;
  end

  // Taken bits update and result formation at finish or map read.
  always_comb begin
    taken_d   = taken_q;
    rsp_vld_d = 1'b0;
    rsp_d     = rsp_q;
    if (cmd_i.map_rd) begin
      rsp_vld_d                = 1'b1;
      rsp_d.status             = STS_MAP;
      rsp_d.slot_number        = '0;
      rsp_d.occupancy_bits     = map_bits;
    end else if (cmd_i.finish) begin
      rsp_vld_d            = 1'b1;
      rsp_d.slot_number    = '0;
      rsp_d.occupancy_bits = '0;
      if (alloc_q) begin
        if (hit_q) begin
          rsp_d.status = STS_HOLDS;
        end else if (free_q) begin
          rsp_d.status        = STS_ALLOCATED;
          rsp_d.slot_number   = SLOT_W'(free_idx_q);
          taken_d[free_idx_q] = 1'b1;
        end else begin
          rsp_d.status = STS_FULL;
        end
      end else begin
        if (hit_q) begin
          rsp_d.status       = STS_RELEASED;
          rsp_d.slot_number  = SLOT_W'(hit_idx_q);
          taken_d[hit_idx_q] = 1'b0;
        end else begin
          rsp_d.status = STS_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      taken_q   <= taken_d;
      rsp_vld_q <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_vld_o = rsp_vld_q;
  assign rsp_o     = rsp_q;

  // Checks on result timing, allocation range and release.
  `FFSA_ASSERT_NEXT(a_rsp_follows_cmd, clk_i, rst_ni, cmd_i.finish || cmd_i.map_rd,
    rsp_vld_q, "result strobe missing after finish or map read")
  `FFSA_ASSERT_SAME(a_alloc_in_range, clk_i, rst_ni,
    rsp_vld_q && (rsp_q.status == STS_ALLOCATED),
    SIU_W'(rsp_q.slot_number) < slots_in_use_q, "slot allocated outside active range")
  `FFSA_ASSERT_NEXT(a_release_clears, clk_i, rst_ni, cmd_i.finish && !alloc_q && hit_q,
    !taken_q[$past(hit_idx_q)], "released slot still marked taken")

endmodule

// ===== hw/rtl/ffsa_ctrl.sv =====
module ffsa_ctrl import ffsa_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [ACTION_W-1:0] action_i,
  input  dp_sts_t             sts_i,
  output dp_cmd_t             cmd_o,
  output logic                busy
);

  ctrl_state_e state_q, state_d;
  logic        is_scan;

  // Allocate and release need a tag scan; everything else is a map read.
  assign is_scan = (action_i == ACT_ALLOC) || (action_i == ACT_RELEASE);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start && is_scan) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN:  state_d = S_FINISH;
      S_FINISH: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy         = 1'b0;
        cmd_o.load   = start;
        cmd_o.map_rd = start && !is_scan;
      end
      S_SCAN:   cmd_o.issue  = 1'b1;
      S_DRAIN:  cmd_o        = '0;
      S_FINISH: cmd_o.finish = 1'b1;
      default:  cmd_o        = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/first_free_slot_allocator.sv =====
// First-fit slot allocator with owner tags.
// A request beat is taken at a clock edge where start is high and busy is low.
// Its action selects allocate, release or an occupancy map read; action 3
// reads the map as well. Each request gives exactly one result beat, shown on
// rsp_o for one cycle while done_o is high; the receiver cannot stall it.
// A map read answers in the cycle after the request and leaves busy low, so
// map reads can follow one per cycle.
// Allocate and release scan the owner tag memory one entry per cycle through
// its single read port, then pass through the drain and finish states; the
// result is registered after finish, and the next request is taken in the
// cycle the result is shown. The active slot limit is written through
// cfg_we_i and cfg_wdata_i; the user must write it only while the block is
// idle, as the block does not enforce it; values above MaxSlots act as MaxSlots.
// Reset clears all taken bits and sets the limit to 64; the owner tags need
// no clearing since a tag is only compared while its slot is taken.
module first_free_slot_allocator import ffsa_pkg::*; #(
  parameter int unsigned MaxSlots = MAX_SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SIU_W-1:0] cfg_wdata_i,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             done_o,
  output rsp_t             rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer for the tag scan.
  ffsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (req_i.action),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  // Tag memory, taken bits and result register.
  ffsa_datapath #(
    .MaxSlots (MaxSlots)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .rsp_vld_o   (done_o),
    .rsp_o       (rsp_o)
  );

endmodule
